@@ rtl/one_point_motion_hypothesis_and_error_macros.svh @@
// Assertion macros for the one-point motion block.
`ifndef ONE_POINT_MOTION_HYPOTHESIS_AND_ERROR_MACROS_SVH
`define ONE_POINT_MOTION_HYPOTHESIS_AND_ERROR_MACROS_SVH

// Same-cycle implication.
`define OPMH_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles.
`define OPMH_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

@@ rtl/opmh_pkg.sv @@
package opmh_pkg;

	typedef struct packed {
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
	} in_item_t;

	typedef struct packed {
		logic signed [14:0] turn_angle;
		logic               angle_degenerate;
		logic [23:0]        epipolar_error;
		logic               error_degenerate;
	} out_item_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 2'd1;
	localparam logic signed [15:0] COS_RESET = 16'sd16384;
	localparam logic signed [15:0] SIN_RESET = 16'sd0;

	localparam int CORDIC_W = 36;
	localparam int ANGLE_W  = 33;
	localparam int QUO_W    = 24;

	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [17:0] ANGLE_LIMIT = 18'sd12868;
	localparam logic [QUO_W-1:0]   ERR_MAX     = 24'hFFFFFF;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] xv;
		logic signed [CORDIC_W-1:0] yv;
		logic                       deg;
	} ang_init_t;

	typedef struct packed {
		logic [63:0]      rem;
		logic [QUO_W-1:0] quo;
		logic [63:0]      den;
		logic             sat;
	} div_t;

	typedef struct packed {
		div_t div;
		logic deg;
	} cordic_sb_t;

	typedef struct packed {
		logic signed [14:0] angle;
		logic               deg;
	} ang_res_t;

	// arctan(2^-i) in Q.30 radians, truncated
	function automatic logic signed [31:0] atan_q30(input int unsigned step);
		logic signed [31:0] r;
		unique case (step)
			0: r = 32'sd843314856;
			1: r = 32'sd497837829;
			2: r = 32'sd263043836;
			3: r = 32'sd133525158;
			4: r = 32'sd67021686;
			5: r = 32'sd33543515;
			6: r = 32'sd16775850;
			7: r = 32'sd8388437;
			8: r = 32'sd4194282;
			9: r = 32'sd2097149;
			10: r = 32'sd1048575;
			11: r = 32'sd524287;
			12: r = 32'sd262143;
			13: r = 32'sd131071;
			14: r = 32'sd65535;
			15: r = 32'sd32767;
			16: r = 32'sd16383;
			17: r = 32'sd8191;
			18: r = 32'sd4095;
			19: r = 32'sd2047;
			20: r = 32'sd1023;
			21: r = 32'sd511;
			22: r = 32'sd255;
			23: r = 32'sd127;
			24: r = 32'sd63;
			25: r = 32'sd31;
			26: r = 32'sd15;
			27: r = 32'sd7;
			28: r = 32'sd3;
			29: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/one_point_motion_hypothesis_and_error.sv @@
// One-point planar motion: turn-angle hypothesis and epipolar error per pair.
// Input: item (four Q3.12 coordinates) is taken at every clock edge where
// start is high and busy is low. busy stays low, so a new pair may enter
// every cycle; throughput is one pair per cycle.
// Output: done pulses for one cycle with result valid; there is no stall on
// the result side, the receiver must take it in that cycle.
// Pipeline: registered stages of products, squares and the 88-bit
// dividend, one CORDIC cell per micro-rotation, a register for angle
// wrap and rounding, then one cell per quotient bit of the 24-bit
// restoring divider.
// Configuration: cfg_index selects cos_half_angle (0) or sin_half_angle (1);
// cfg_ready is always high and other indexes are dropped. Write only while
// no transaction is in flight.
// Reset: clears all valid bits and loads cos 1.0 and sin 0.0; pairs in
// flight are lost.
`include "one_point_motion_hypothesis_and_error_macros.svh"

module one_point_motion_hypothesis_and_error #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  opmh_pkg::in_item_t                     item,
	output logic                                   done,
	output opmh_pkg::out_item_t                    result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [opmh_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [15:0]                            cfg_data
);

	localparam int LAT   = 32 + CORDIC_STEPS;
	localparam int CW    = opmh_pkg::CORDIC_W;
	localparam int ZW    = opmh_pkg::ANGLE_W;
	localparam int QW    = opmh_pkg::QUO_W;
	localparam int CSB_W = $bits(opmh_pkg::cordic_sb_t);
	localparam int DSB_W = $bits(opmh_pkg::ang_res_t);

	logic signed [15:0] cos_q, sin_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= opmh_pkg::COS_RESET;
			sin_q <= opmh_pkg::SIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == opmh_pkg::REG_COS) begin
				cos_q <= cfg_data;
			end else if (cfg_index == opmh_pkg::REG_SIN) begin
				sin_q <= cfg_data;
			end
		end
	end

	// stage 1: products
	logic               accept;
	logic signed [16:0] ysum, den;
	logic               v_s1;
	logic signed [31:0] p21_s1, p12_s1, cy1_s1, cx1_s1, cy2_s1, cx2_s1;
	logic signed [32:0] sy_s1;
	logic signed [16:0] den_s1;

	assign accept = start && !busy;
	assign ysum   = {item.first_y[15], item.first_y} + {item.second_y[15], item.second_y};
	assign den    = {item.second_y[15], item.second_y} - {item.first_y[15], item.first_y};

	always_ff @(posedge clk) begin
		p21_s1 <= item.second_x * item.first_y;
		p12_s1 <= item.first_x * item.second_y;
		cy1_s1 <= cos_q * item.first_y;
		cx1_s1 <= cos_q * item.first_x;
		cy2_s1 <= cos_q * item.second_y;
		cx2_s1 <= cos_q * item.second_x;
		sy_s1  <= sin_q * ysum;
		den_s1 <= den;
	end

	// stage 2: CORDIC start vector, cross term, absolute gradient terms
	opmh_pkg::ang_init_t ang_n;
	logic signed [CW-1:0] yw, xw;
	logic signed [33:0]   t2, t4, s12;
	logic                 v_s2;
	opmh_pkg::ang_init_t  ang_s2;
	logic signed [32:0]   cross_s2, sy_s2;
	logic [31:0]          a1_s2, a2_s2, a3_s2, a4_s2;

	always_comb begin
		yw  = CW'(p21_s1) + CW'(p12_s1);
		xw  = CW'(den_s1) <<< 12;
		s12 = 34'(sin_q) <<< 12;
		t2  = 34'(cx1_s1) - s12;
		t4  = 34'(cx2_s1) + s12;
		ang_n.deg = (den_s1 == 17'sd0);
		if (den_s1[16]) begin
			ang_n.xv = -xw;
			ang_n.yv = -yw;
		end else begin
			ang_n.xv = xw;
			ang_n.yv = yw;
		end
	end

	always_ff @(posedge clk) begin
		ang_s2   <= ang_n;
		cross_s2 <= 33'(p12_s1) - 33'(p21_s1);
		sy_s2    <= sy_s1;
		a1_s2    <= cy1_s1[31] ? 32'(-cy1_s1) : 32'(cy1_s1);
		a2_s2    <= t2[33] ? 32'(-t2) : 32'(t2);
		a3_s2    <= cy2_s1[31] ? 32'(-cy2_s1) : 32'(cy2_s1);
		a4_s2    <= t4[33] ? 32'(-t4) : 32'(t4);
	end

	// stage 3: numerator and squared gradient terms
	logic signed [48:0]  cprod;
	logic                v_s3;
	opmh_pkg::ang_init_t ang_s3;
	logic signed [49:0]  n_s3;
	logic [63:0]         q1_s3, q2_s3, q3_s3, q4_s3;

	assign cprod = cos_q * cross_s2;

	always_ff @(posedge clk) begin
		ang_s3 <= ang_s2;
		n_s3   <= 50'(cprod) - (50'(sy_s2) <<< 12);
		q1_s3  <= a1_s2 * a1_s2;
		q2_s3  <= a2_s2 * a2_s2;
		q3_s3  <= a3_s2 * a3_s2;
		q4_s3  <= a4_s2 * a4_s2;
	end

	// stage 4: |N| and denominator
	logic signed [49:0]  nabs;
	logic                v_s4;
	opmh_pkg::ang_init_t ang_s4;
	logic [47:0]         na_s4;
	logic [63:0]         d_s4;

	assign nabs = n_s3[49] ? -n_s3 : n_s3;

	always_ff @(posedge clk) begin
		ang_s4 <= ang_s3;
		na_s4  <= nabs[47:0];
		d_s4   <= q1_s3 + q2_s3 + q3_s3 + q4_s3;
	end

	// stage 5: partial products of N squared
	logic                v_s5;
	opmh_pkg::ang_init_t ang_s5;
	logic [47:0]         ph_s5, pm_s5, pl_s5;
	logic [63:0]         d_s5;

	always_ff @(posedge clk) begin
		ang_s5 <= ang_s4;
		d_s5   <= d_s4;
		ph_s5  <= na_s4[47:24] * na_s4[47:24];
		pm_s5  <= na_s4[47:24] * na_s4[23:0];
		pl_s5  <= na_s4[23:0] * na_s4[23:0];
	end

	// stage 6: dividend N^2 / 256
	logic [95:0]         nsq;
	logic                v_s6;
	opmh_pkg::ang_init_t ang_s6;
	logic [87:0]         m_s6;
	logic [63:0]         d_s6;

	assign nsq = (96'(ph_s5) << 48) + (96'(pm_s5) << 25) + 96'(pl_s5);

	always_ff @(posedge clk) begin
		ang_s6 <= ang_s5;
		d_s6   <= d_s5;
		m_s6   <= nsq[95:8];
	end

	// stage 7: overflow check and divider start
	logic                v_s7;
	opmh_pkg::ang_init_t ang_s7;
	opmh_pkg::div_t      div_s7;

	always_ff @(posedge clk) begin
		ang_s7     <= ang_s6;
		div_s7.rem <= m_s6[87:24];
		div_s7.quo <= m_s6[23:0];
		div_s7.den <= d_s6;
		div_s7.sat <= (m_s6 >= {d_s6, 24'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// CORDIC chain
	opmh_pkg::cordic_sb_t csb_in, csb_out;
	logic                 cv [0:CORDIC_STEPS];
	logic signed [CW-1:0] cx [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy [0:CORDIC_STEPS];
	logic signed [ZW-1:0] cz [0:CORDIC_STEPS];
	logic [CSB_W-1:0]     csb [0:CORDIC_STEPS];

	assign csb_in.div = div_s7;
	assign csb_in.deg = ang_s7.deg;
	assign cv[0]  = v_s7;
	assign cx[0]  = ang_s7.xv;
	assign cy[0]  = ang_s7.yv;
	assign cz[0]  = '0;
	assign csb[0] = csb_in;
	assign csb_out = csb[CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		opmh_cordic_cell #(
			.STEP(i),
			.SB_W(CSB_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (cv[i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.sb_in    (csb[i]),
			.valid_out(cv[i+1]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.sb_out   (csb[i+1])
		);
	end

	// angle doubling, wrap, rounding to Q1.13
	logic signed [33:0]  a2x, aw;
	logic signed [34:0]  ar;
	logic signed [17:0]  rr;
	opmh_pkg::ang_res_t  res_n;
	logic                pv_s1;
	opmh_pkg::ang_res_t  res_s1;
	opmh_pkg::div_t      div_p_s1;

	always_comb begin
		a2x = 34'(cz[CORDIC_STEPS]) <<< 1;
		aw  = a2x;
		if (aw > opmh_pkg::HALF_PI_Q30) begin
			aw = aw - opmh_pkg::PI_Q30;
		end
		if (aw < -opmh_pkg::HALF_PI_Q30) begin
			aw = aw + opmh_pkg::PI_Q30;
		end
		ar = 35'(aw) + 35'sd65536;
		rr = ar[34:17];
		if (rr > opmh_pkg::ANGLE_LIMIT) begin
			rr = opmh_pkg::ANGLE_LIMIT;
		end
		if (rr < -opmh_pkg::ANGLE_LIMIT) begin
			rr = -opmh_pkg::ANGLE_LIMIT;
		end
		res_n.deg   = csb_out.deg;
		res_n.angle = csb_out.deg ? 15'sd0 : rr[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		res_s1   <= res_n;
		div_p_s1 <= csb_out.div;
	end

	// restoring divider, one quotient bit per cell
	logic               dv  [0:QW];
	opmh_pkg::div_t     dd  [0:QW];
	logic [DSB_W-1:0]   dsb [0:QW];
	opmh_pkg::ang_res_t res_out;

	assign dv[0]  = pv_s1;
	assign dd[0]  = div_p_s1;
	assign dsb[0] = res_s1;

	for (genvar j = 0; j < QW; j++) begin : g_div
		opmh_div_cell #(
			.SB_W(DSB_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (dv[j]),
			.div_in   (dd[j]),
			.sb_in    (dsb[j]),
			.valid_out(dv[j+1]),
			.div_out  (dd[j+1]),
			.sb_out   (dsb[j+1])
		);
	end

	assign res_out = dsb[QW];
	assign done    = dv[QW];

	always_comb begin
		result.turn_angle       = res_out.angle;
		result.angle_degenerate = res_out.deg;
		result.epipolar_error   = dd[QW].sat ? opmh_pkg::ERR_MAX : dd[QW].quo;
		result.error_degenerate = dd[QW].sat;
	end

	`OPMH_ASSERT_DELAY(a_latency, accept, LAT, done, "transaction result not on time")
	`OPMH_ASSERT_IMPLY(a_deg_zero, done && result.angle_degenerate, result.turn_angle == 15'sd0, "degenerate angle not zero")
	`OPMH_ASSERT_IMPLY(a_angle_range, done, (result.turn_angle <= 15'sd12868) && (result.turn_angle >= -15'sd12868), "turn angle out of range")
	`OPMH_ASSERT_IMPLY(a_sat_max, done && result.error_degenerate, result.epipolar_error == opmh_pkg::ERR_MAX, "flagged error not saturated")

endmodule

@@ rtl/opmh_cordic_cell.sv @@
module opmh_cordic_cell #(
	parameter int STEP = 0,
	parameter int SB_W = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_in,
	input  logic signed [opmh_pkg::CORDIC_W-1:0]   x_in,
	input  logic signed [opmh_pkg::CORDIC_W-1:0]   y_in,
	input  logic signed [opmh_pkg::ANGLE_W-1:0]    z_in,
	input  logic [SB_W-1:0]                        sb_in,
	output logic                                   valid_out,
	output logic signed [opmh_pkg::CORDIC_W-1:0]   x_out,
	output logic signed [opmh_pkg::CORDIC_W-1:0]   y_out,
	output logic signed [opmh_pkg::ANGLE_W-1:0]    z_out,
	output logic [SB_W-1:0]                        sb_out
);

	logic signed [opmh_pkg::CORDIC_W-1:0] xs, ys, x_n, y_n;
	logic signed [opmh_pkg::ANGLE_W-1:0]  at, z_n;

	always_comb begin
		xs = x_in >>> STEP;
		ys = y_in >>> STEP;
		at = opmh_pkg::ANGLE_W'(opmh_pkg::atan_q30(STEP));
		if (!y_in[opmh_pkg::CORDIC_W-1]) begin
			x_n = x_in + ys;
			y_n = y_in - xs;
			z_n = z_in + at;
		end else begin
			x_n = x_in - ys;
			y_n = y_in + xs;
			z_n = z_in - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		x_out  <= x_n;
		y_out  <= y_n;
		z_out  <= z_n;
		sb_out <= sb_in;
	end

endmodule

@@ rtl/opmh_div_cell.sv @@
module opmh_div_cell #(
	parameter int SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  opmh_pkg::div_t    div_in,
	input  logic [SB_W-1:0]   sb_in,
	output logic              valid_out,
	output opmh_pkg::div_t    div_out,
	output logic [SB_W-1:0]   sb_out
);

	logic [64:0]    trial, diff;
	logic           ge;
	opmh_pkg::div_t div_n;

	always_comb begin
		trial = {div_in.rem, div_in.quo[opmh_pkg::QUO_W-1]};
		diff  = trial - {1'b0, div_in.den};
		ge    = !diff[64];
		div_n = div_in;
		div_n.rem = ge ? diff[63:0] : trial[63:0];
		div_n.quo = {div_in.quo[opmh_pkg::QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		div_out <= div_n;
		sb_out  <= sb_in;
	end

endmodule

@@ verif/one_point_motion_hypothesis_and_error_test.sv @@
module one_point_motion_hypothesis_and_error_test;
	timeunit 1ns;
	timeprecision 1ps;

	class motion_scoreboard;
		logic signed [15:0]  cos_half;
		logic signed [15:0]  sin_half;
		opmh_pkg::out_item_t expected_q[$];
		int                  mismatches;
		int                  checked;
		longint              arctan_tab[14] = '{843314856, 497837829, 263043836, 133525158,
			67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071};

		function new();
			cos_half = opmh_pkg::COS_RESET;
			sin_half = opmh_pkg::SIN_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [opmh_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
			if (idx == opmh_pkg::REG_COS)
				cos_half = data;
			else if (idx == opmh_pkg::REG_SIN)
				sin_half = data;
		endfunction

		function logic [127:0] square_abs(longint v);
			logic [127:0] u;
			u = (v < 0) ? -v : v;
			return u * u;
		endfunction

		function opmh_pkg::out_item_t motion_of(opmh_pkg::in_item_t it);
			opmh_pkg::out_item_t r;
			longint       x1, y1, x2, y2, span, xv, yv, nx, ny, z, a, q13, c, s, n;
			logic [127:0] na, nsq, d, quo;
			x1 = it.first_x;
			y1 = it.first_y;
			x2 = it.second_x;
			y2 = it.second_y;
			span = y2 - y1;
			if (span == 0) begin
				r.turn_angle = '0;
				r.angle_degenerate = 1'b1;
			end else begin
				yv = x2 * y1 + x1 * y2;
				xv = span * 4096;
				if (xv < 0) begin
					xv = -xv;
					yv = -yv;
				end
				z = 0;
				for (int i = 0; i < 14; i++) begin
					if (yv >= 0) begin
						nx = xv + (yv >>> i);
						ny = yv - (xv >>> i);
						z += arctan_tab[i];
					end else begin
						nx = xv - (yv >>> i);
						ny = yv + (xv >>> i);
						z -= arctan_tab[i];
					end
					xv = nx;
					yv = ny;
				end
				a = 2 * z;
				if (a > 64'sd1686629713)
					a -= 64'sd3373259426;
				if (a < -64'sd1686629713)
					a += 64'sd3373259426;
				q13 = (a + 65536) >>> 17;
				if (q13 > 12868)
					q13 = 12868;
				if (q13 < -12868)
					q13 = -12868;
				r.turn_angle = q13[14:0];
				r.angle_degenerate = 1'b0;
			end
			c = cos_half;
			s = sin_half;
			n = c * (x1 * y2 - x2 * y1) - s * (y1 + y2) * 4096;
			d = square_abs(c * y1) + square_abs(c * x1 - s * 4096)
				+ square_abs(c * y2) + square_abs(c * x2 + s * 4096);
			na = (n < 0) ? -n : n;
			nsq = (na * na) >> 8;
			if (d == 0) begin
				r.epipolar_error = 24'hFFFFFF;
				r.error_degenerate = 1'b1;
			end else begin
				quo = nsq / d;
				if (quo >= 128'd16777216) begin
					r.epipolar_error = 24'hFFFFFF;
					r.error_degenerate = 1'b1;
				end else begin
					r.epipolar_error = quo[23:0];
					r.error_degenerate = 1'b0;
				end
			end
			return r;
		endfunction

		function void note_pair(opmh_pkg::in_item_t it);
			expected_q.push_back(motion_of(it));
		endfunction

		function void check_result(opmh_pkg::out_item_t got);
			opmh_pkg::out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with no transaction outstanding");
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.turn_angle !== want.turn_angle) begin
				$error("turn_angle: expected %0d, got %0d", want.turn_angle, got.turn_angle);
				mismatches++;
			end
			if (got.angle_degenerate !== want.angle_degenerate) begin
				$error("angle_degenerate: expected %0b, got %0b",
					want.angle_degenerate, got.angle_degenerate);
				mismatches++;
			end
			if (got.epipolar_error !== want.epipolar_error) begin
				$error("epipolar_error: expected %0d, got %0d",
					want.epipolar_error, got.epipolar_error);
				mismatches++;
			end
			if (got.error_degenerate !== want.error_degenerate) begin
				$error("error_degenerate: expected %0b, got %0b",
					want.error_degenerate, got.error_degenerate);
				mismatches++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	opmh_pkg::in_item_t             item;
	logic                           done;
	opmh_pkg::out_item_t            result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [opmh_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                    cfg_data;

	motion_scoreboard sb = new();
	int               idle_pct;
	int               settings_used;

	one_point_motion_hypothesis_and_error dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task automatic send_pair(opmh_pkg::in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		sb.note_pair(it);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [opmh_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] coord_of(int mode);
		case (mode)
			0: return 16'($signed($urandom_range(4096)) - 2048);
			1: return 16'($signed($urandom_range(256)) - 128);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic opmh_pkg::in_item_t random_pair();
		opmh_pkg::in_item_t it;
		int                 mode;
		mode = $urandom_range(3);
		it.first_x = coord_of(mode);
		it.first_y = coord_of(mode);
		it.second_x = coord_of(mode);
		it.second_y = coord_of(mode);
		if ($urandom_range(9) == 0)
			it.second_y = it.first_y;
		return it;
	endfunction

	task automatic directed_pairs();
		opmh_pkg::in_item_t v[$];
		v.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		v.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		v.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
		v.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF});
		v.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000});
		v.push_back('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF});
		v.push_back('{16'sh1000, 16'sh0000, 16'sh1000, 16'sh0001});
		v.push_back('{16'sh1000, 16'sh0001, 16'sh1000, 16'sh0000});
		v.push_back('{16'sh1000, 16'sh0400, 16'sh1000, 16'sh0400});
		v.push_back('{16'sh0000, 16'sh1000, 16'sh0000, 16'shF000});
		v.push_back('{16'sh0800, 16'sh0000, 16'shF800, 16'sh0010});
		v.push_back('{16'sh0800, 16'sh0000, 16'sh0800, 16'shFFF0});
		v.push_back('{16'sh0100, 16'sh0200, 16'sh0100, 16'sh0300});
		v.push_back('{16'shFFFF, 16'sh0001, 16'sh0001, 16'shFFFF});
		v.push_back('{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555});
		foreach (v[i])
			send_pair(v[i]);
	endtask

	initial begin
		logic [15:0] cos_set[7];
		logic [15:0] sin_set[7];
		cos_set = '{16'd16384, 16'd0, 16'hC000, 16'h7FFF, 16'h8000, 16'd11585, 16'd0};
		sin_set = '{16'd0, 16'd0, 16'd16384, 16'h8000, 16'h7FFF, 16'd11585, 16'd3000};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		settings_used = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_pairs();
		drain();
		for (int p = 0; p < 8; p++) begin
			if (p < 7) begin
				write_reg(opmh_pkg::REG_COS, cos_set[p]);
				write_reg(opmh_pkg::REG_SIN, sin_set[p]);
			end else begin
				write_reg(opmh_pkg::REG_COS, 16'($urandom));
				write_reg(opmh_pkg::REG_SIN, 16'($urandom));
				write_reg(2'd2, 16'($urandom));
				write_reg(2'd3, 16'($urandom));
			end
			settings_used++;
			if (p == 1)
				directed_pairs();
			for (int k = 0; k < 165; k++) begin
				case ((k * 4) / 165)
					0: idle_pct = 0;
					1: idle_pct = 84;
					2: idle_pct = 0;
					default: idle_pct = 14;
				endcase
				send_pair(random_pair());
			end
			idle_pct = 0;
			drain();
		end
		$display("checked %0d pair results over %0d register settings, idle mixes 0/84/14 pct",
			sb.checked, settings_used + 1);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule
